// ===== rtl/adnp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adnp_pkg: shared types and constants of the advertising-data name parser
// Result layout, register map and the AD type and character codes.
// ----------------------------------------------------------------------------
package adnp_pkg;

	// Widths of the item fields
	localparam int unsigned DATA_W = 8;
	localparam int unsigned REM_W  = 8;
	localparam int unsigned IDX_W  = 6;
	localparam int unsigned CAP_W  = 7;
	localparam int unsigned APB_W  = 32;
	localparam int unsigned ADDR_W = 3;

	// Default bound on the name buffer, terminator included
	localparam int unsigned MAX_NAME_BYTES_DEF = 64;

	// Register map: word index taken from paddr[2]
	localparam logic REG_NAME_CAPACITY = 1'b0;

	// Capacity after reset
	localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd32;

	// AD structure types of interest
	localparam logic [DATA_W-1:0] AD_SHORT_NAME    = 8'd8;
	localparam logic [DATA_W-1:0] AD_COMPLETE_NAME = 8'd9;

	// Printable range and the substitute character
	localparam logic [DATA_W-1:0] CHAR_FIRST = 8'd32;
	localparam logic [DATA_W-1:0] CHAR_LAST  = 8'd126;
	localparam logic [DATA_W-1:0] CHAR_DOT   = 8'd46;

	// One result item
	typedef struct packed {
		logic              char_write;
		logic [IDX_W-1:0]  char_index;
		logic [DATA_W-1:0] char_value;
		logic [IDX_W-1:0]  name_length;
		logic              name_is_complete;
		logic              record_done;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/adnp_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adnp_in_if: advertising-data byte channel
// One record byte and the count of record bytes that follow it.
// ----------------------------------------------------------------------------
interface adnp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [7:0] bytes_remaining;

	modport source (output valid, output data_byte, output bytes_remaining, input ready);
	modport sink   (input valid, input data_byte, input bytes_remaining, output ready);
endinterface
`default_nettype wire

// ===== rtl/adnp_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adnp_out_if: name parser result channel
// Character write, running name length and record status for each byte.
// ----------------------------------------------------------------------------
interface adnp_out_if;
	logic       valid;
	logic       ready;
	logic       char_write;
	logic [5:0] char_index;
	logic [7:0] char_value;
	logic [5:0] name_length;
	logic       name_is_complete;
	logic       record_done;

	modport source (
		output valid, output char_write, output char_index, output char_value,
		output name_length, output name_is_complete, output record_done,
		input ready
	);
	modport sink (
		input valid, input char_write, input char_index, input char_value,
		input name_length, input name_is_complete, input record_done,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/adv_data_name_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adv_data_name_parser: local-name extractor for advertising data
// Walks AD structures one byte per item and reports name characters.
// ----------------------------------------------------------------------------
// One record byte is taken per clock on rec unless res back-pressures, and it
// gives exactly one result on res, through the input register, then the result
// register. The parse state is updated in a single registered pass, so a new
// byte can be accepted in every cycle, sustaining one item per clock whenever
// res is ready. The name capacity register sits at byte address 0 of the APB
// port; write it only while no record is in flight. There is no clearing pass
// after reset: the block accepts items as soon as reset is released.
// ----------------------------------------------------------------------------
module adv_data_name_parser #(
	parameter int unsigned MAX_NAME_BYTES = adnp_pkg::MAX_NAME_BYTES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	adnp_in_if.sink                           rec,
	adnp_out_if.source                        res,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [adnp_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [adnp_pkg::APB_W-1:0]   pwdata,
	output logic      [adnp_pkg::APB_W-1:0]   prdata,
	output logic                              pready
);
	import adnp_pkg::*;

	logic [CAP_W-1:0]  capacity_q;
	logic              cap_sel;

	logic              valid_s1;
	logic [DATA_W-1:0] data_byte_s1;
	logic [REM_W-1:0]  bytes_rem_s1;

	logic              out_valid_q;
	result_t           out_q;
	result_t           core_res;

	logic              out_free;
	logic              advance;

	// Configuration register
	assign cap_sel = (paddr[2] == REG_NAME_CAPACITY);
	assign pready  = 1'b1;
	assign prdata  = cap_sel ? APB_W'(capacity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (psel && penable && pwrite && cap_sel) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	// Flow control: the input stage moves on when the result register frees
	assign out_free  = !out_valid_q || res.ready;
	assign advance   = valid_s1 && out_free;
	assign rec.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rec.ready) begin
				valid_s1 <= rec.valid;
			end
			if (out_free) begin
				out_valid_q <= advance;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (rec.valid && rec.ready) begin
			data_byte_s1 <= rec.data_byte;
			bytes_rem_s1 <= rec.bytes_remaining;
		end
		if (advance) begin
			out_q <= core_res;
		end
	end

	// Parser
	adnp_core #(
		.MAX_NAME_BYTES (MAX_NAME_BYTES)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (advance),
		.data_byte       (data_byte_s1),
		.bytes_remaining (bytes_rem_s1),
		.name_capacity   (capacity_q),
		.result          (core_res)
	);

	// Result port
	assign res.valid            = out_valid_q;
	assign res.char_write       = out_q.char_write;
	assign res.char_index       = out_q.char_index;
	assign res.char_value       = out_q.char_value;
	assign res.name_length      = out_q.name_length;
	assign res.name_is_complete = out_q.name_is_complete;
	assign res.record_done      = out_q.record_done;

	// Every advanced item shows up in the result register
	a_adv_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced item lost before result register");

	// A written character is the last one of the current name
	a_write_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.char_write |-> out_q.char_index + IDX_W'(1) == out_q.name_length)
		else $error("name length does not follow the written character");

	// No character fields without a write
	a_idle_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.char_write |-> out_q.char_index == '0 && out_q.char_value == '0)
		else $error("character fields set without a write");

	// Written characters are printable or the substitute
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.char_write |->
			(out_q.char_value >= CHAR_FIRST && out_q.char_value <= CHAR_LAST) ||
			out_q.char_value == CHAR_DOT)
		else $error("non-printable character written");

endmodule
`default_nettype wire

// ===== rtl/adnp_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adnp_core: AD structure walker and name extractor
// Holds the parse state, updates it once per advanced item and forms the result.
// ----------------------------------------------------------------------------
module adnp_core #(
	parameter int unsigned MAX_NAME_BYTES = adnp_pkg::MAX_NAME_BYTES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         advance,
	input  wire logic [adnp_pkg::DATA_W-1:0]  data_byte,
	input  wire logic [adnp_pkg::REM_W-1:0]   bytes_remaining,
	input  wire logic [adnp_pkg::CAP_W-1:0]   name_capacity,
	output adnp_pkg::result_t                 result
);
	import adnp_pkg::*;

	// Largest usable capacity: the buffer bound, never above the 6-bit index range
	localparam logic [CAP_W-1:0] CAP_LIMIT =
		CAP_W'((MAX_NAME_BYTES < 64) ? MAX_NAME_BYTES : 64);

	typedef enum logic [1:0] {
		PH_LENGTH,
		PH_TYPE,
		PH_PAYLOAD,
		PH_STOPPED
	} phase_t;

	phase_t            phase_q,     phase_n;
	logic [REM_W-1:0]  left_q,      left_n;
	logic              is_name_q,   is_name_n;
	logic              is_cpl_q,    is_cpl_n;
	logic [IDX_W-1:0]  wpos_q,      wpos_n;
	logic [IDX_W-1:0]  copy_lim_q,  copy_lim_n;
	logic [IDX_W-1:0]  name_len_q,  name_len_n;
	logic              cpl_found_q, cpl_found_n;

	logic [CAP_W-1:0]  cap;
	logic              cap_nz;
	logic [CAP_W-1:0]  lim;
	logic [REM_W-1:0]  left_dec;
	logic              printable;

	// Effective capacity and copy limit
	assign cap       = (name_capacity > CAP_LIMIT) ? CAP_LIMIT : name_capacity;
	assign cap_nz    = (cap != '0);
	assign lim       = cap_nz ? (cap - CAP_W'(1)) : '0;
	assign left_dec  = left_q - REM_W'(1);
	assign printable = (data_byte >= CHAR_FIRST) && (data_byte <= CHAR_LAST);

	// Next parse state and this item's character write
	always_comb begin
		phase_n     = phase_q;
		left_n      = left_q;
		is_name_n   = is_name_q;
		is_cpl_n    = is_cpl_q;
		wpos_n      = wpos_q;
		copy_lim_n  = copy_lim_q;
		name_len_n  = name_len_q;
		cpl_found_n = cpl_found_q;
		result.char_write = 1'b0;
		result.char_index = '0;
		result.char_value = '0;

		unique case (phase_q)
			PH_LENGTH: begin
				// zero or overrunning length stops the parse
				if ((data_byte == '0) || (data_byte > bytes_remaining)) begin
					phase_n = PH_STOPPED;
				end else begin
					left_n  = data_byte;
					phase_n = PH_TYPE;
				end
			end
			PH_TYPE: begin
				left_n = left_dec;
				if ((data_byte == AD_SHORT_NAME) || (data_byte == AD_COMPLETE_NAME)) begin
					// a new name structure replaces any earlier name
					is_name_n   = 1'b1;
					is_cpl_n    = (data_byte == AD_COMPLETE_NAME);
					wpos_n      = '0;
					copy_lim_n  = ({1'b0, lim} > left_dec) ? left_dec[IDX_W-1:0]
					                                       : lim[IDX_W-1:0];
					name_len_n  = '0;
					cpl_found_n = (data_byte == AD_COMPLETE_NAME);
				end else begin
					is_name_n = 1'b0;
					is_cpl_n  = 1'b0;
				end
				if (left_dec == '0) begin
					phase_n = (is_name_n && is_cpl_n) ? PH_STOPPED : PH_LENGTH;
				end else begin
					phase_n = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (is_name_q && (wpos_q < copy_lim_q) && cap_nz) begin
					result.char_write = 1'b1;
					result.char_index = wpos_q;
					result.char_value = printable ? data_byte : CHAR_DOT;
					wpos_n            = wpos_q + IDX_W'(1);
					name_len_n        = wpos_q + IDX_W'(1);
				end
				left_n = left_dec;
				if (left_dec == '0) begin
					phase_n = (is_name_q && is_cpl_q) ? PH_STOPPED : PH_LENGTH;
				end
			end
			PH_STOPPED: begin
				// rest of the record is ignored
			end
		endcase

		result.name_length      = cap_nz ? name_len_n : '0;
		result.name_is_complete = cap_nz ? cpl_found_n : 1'b0;
		result.record_done      = (bytes_remaining == '0);
	end

	// Parse state; the end of a record returns everything to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LENGTH;
			left_q      <= '0;
			is_name_q   <= 1'b0;
			is_cpl_q    <= 1'b0;
			wpos_q      <= '0;
			copy_lim_q  <= '0;
			name_len_q  <= '0;
			cpl_found_q <= 1'b0;
		end else if (advance) begin
			if (bytes_remaining == '0) begin
				phase_q     <= PH_LENGTH;
				left_q      <= '0;
				is_name_q   <= 1'b0;
				is_cpl_q    <= 1'b0;
				wpos_q      <= '0;
				copy_lim_q  <= '0;
				name_len_q  <= '0;
				cpl_found_q <= 1'b0;
			end else begin
				phase_q     <= phase_n;
				left_q      <= left_n;
				is_name_q   <= is_name_n;
				is_cpl_q    <= is_cpl_n;
				wpos_q      <= wpos_n;
				copy_lim_q  <= copy_lim_n;
				name_len_q  <= name_len_n;
				cpl_found_q <= cpl_found_n;
			end
		end
	end

	// Copy position never passes the copy limit
	a_wpos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wpos_q <= copy_lim_q)
		else $error("write position beyond copy limit");

	// Name length tracks the write position
	a_len_tracks_pos: assert property (@(posedge clk) disable iff (!arst_n)
		name_len_q == wpos_q)
		else $error("name length out of step with write position");

	// Copy limit stays below the effective capacity
	a_limit_cap: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (phase_q == PH_TYPE) && cap_nz |-> {1'b0, copy_lim_n} < cap)
		else $error("copy limit reaches capacity");

endmodule
`default_nettype wire

// ===== bench/tb_adv_data_name_parser.sv =====
// ----------------------------------------------------------------------------
// tb_adv_data_name_parser: self-checking bench for the advertising name parser
// Feeds advertising records byte by byte. A local copy of the parse state
// predicts each result, and the result stream is checked field by field in
// order. Runs under random stalls on both channels and several capacities.
// ----------------------------------------------------------------------------
module tb_adv_data_name_parser;
	import adnp_pkg::*;

	localparam int unsigned NAME_BOUND     = 64;   // uut keeps its default bound
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES   = 8;
	localparam int unsigned RAND_SEGMENTS  = 9;
	localparam int unsigned SEG_ITEMS      = 25;   // byte count; the last record may overshoot it

	typedef enum logic [1:0] {
		SCAN_LENGTH, SCAN_TYPE, SCAN_PAYLOAD, SCAN_STOPPED
	} scan_phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] bytes_remaining;
	} adv_byte_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [APB_W-1:0]  pwdata;
	wire  [APB_W-1:0]  prdata;
	wire               pready;

	adnp_in_if  rec_ch ();
	adnp_out_if res_ch ();

	adv_data_name_parser uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rec     (rec_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow of the capacity register and of the parse state
	logic [CAP_W-1:0] cap_reg;
	scan_phase_t      scan_phase;
	logic [7:0]       st_left;
	logic             st_name;
	logic             st_complete;
	logic [5:0]       wr_pos;
	logic [5:0]       cp_limit;
	logic [5:0]       name_len;
	logic             cpl_found;

	// Stimulus backlog, record under construction, expected results
	adv_byte_t  byte_backlog[$];
	logic [7:0] rec_buf[$];
	result_t    name_expect[$];

	int unsigned src_idle_pct;
	int unsigned sink_idle_pct;
	int unsigned bytes_accepted;
	int unsigned results_checked;
	int unsigned chars_written;
	int unsigned cap_writes;
	int unsigned mismatches;
	int unsigned stall_cycles;
	adv_byte_t   next_byte;
	result_t     want;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_scan();
		scan_phase  = SCAN_LENGTH;
		st_left     = '0;
		st_name     = 1'b0;
		st_complete = 1'b0;
		wr_pos      = '0;
		cp_limit    = '0;
		name_len    = '0;
		cpl_found   = 1'b0;
	endfunction

	// Predict the result of one record byte and advance the parse state
	function automatic result_t parse_byte(input logic [7:0] b, input logic [7:0] rem);
		result_t    r;
		logic [6:0] cap;
		logic [6:0] lim;
		cap = (cap_reg > 7'(NAME_BOUND)) ? 7'(NAME_BOUND) : cap_reg;
		r = '0;
		case (scan_phase)
			SCAN_LENGTH: begin
				if (b == 8'd0 || b > rem) begin
					scan_phase = SCAN_STOPPED;
				end else begin
					st_left    = b;
					scan_phase = SCAN_TYPE;
				end
			end
			SCAN_TYPE: begin
				st_left = st_left - 8'd1;
				if (b == AD_SHORT_NAME || b == AD_COMPLETE_NAME) begin
					lim         = (cap > 7'd0) ? cap - 7'd1 : 7'd0;
					st_name     = 1'b1;
					st_complete = (b == AD_COMPLETE_NAME);
					wr_pos      = '0;
					cp_limit    = (st_left < 8'(lim)) ? st_left[5:0] : lim[5:0];
					name_len    = '0;
					cpl_found   = st_complete;
				end else begin
					st_name     = 1'b0;
					st_complete = 1'b0;
				end
				if (st_left == 8'd0)
					scan_phase = (st_name && st_complete) ? SCAN_STOPPED : SCAN_LENGTH;
				else
					scan_phase = SCAN_PAYLOAD;
			end
			SCAN_PAYLOAD: begin
				if (st_name && wr_pos < cp_limit && cap > 7'd0) begin
					r.char_write = 1'b1;
					r.char_index = wr_pos;
					r.char_value = (b >= CHAR_FIRST && b <= CHAR_LAST) ? b : CHAR_DOT;
					wr_pos       = wr_pos + 6'd1;
					name_len     = wr_pos;
				end
				st_left = st_left - 8'd1;
				if (st_left == 8'd0)
					scan_phase = (st_name && st_complete) ? SCAN_STOPPED : SCAN_LENGTH;
			end
			default: ;
		endcase
		r.name_length      = (cap > 7'd0) ? name_len : 6'd0;
		r.name_is_complete = (cap > 7'd0) ? cpl_found : 1'b0;
		r.record_done      = (rem == 8'd0);
		if (rem == 8'd0)
			clear_scan();
		return r;
	endfunction

	// Driver: presents backlog bytes, predicts each accepted one
	always @(posedge clk) begin
		if (!arst_n) begin
			rec_ch.valid <= 1'b0;
		end else begin
			if (rec_ch.valid && rec_ch.ready) begin
				name_expect.push_back(parse_byte(rec_ch.data_byte, rec_ch.bytes_remaining));
				bytes_accepted++;
			end
			if (!rec_ch.valid || rec_ch.ready) begin
				if (byte_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					next_byte = byte_backlog.pop_front();
					rec_ch.valid           <= 1'b1;
					rec_ch.data_byte       <= next_byte.data_byte;
					rec_ch.bytes_remaining <= next_byte.bytes_remaining;
				end else begin
					rec_ch.valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string fname, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: mismatch on %s, expected %0d, actual %0d",
				$realtime, fname, exp_v, act_v);
			mismatches++;
		end
	endtask

	// Monitor: checks each accepted result against the oldest prediction
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (name_expect.size() == 0) begin
					$display("%0t: result with nothing expected, expected none, actual %h",
						$realtime, {res_ch.char_write, res_ch.char_index, res_ch.char_value,
						res_ch.name_length, res_ch.name_is_complete, res_ch.record_done});
					mismatches++;
				end else begin
					want = name_expect.pop_front();
					check_field("char_write", want.char_write, res_ch.char_write);
					check_field("char_index", want.char_index, res_ch.char_index);
					check_field("char_value", want.char_value, res_ch.char_value);
					check_field("name_length", want.name_length, res_ch.name_length);
					check_field("name_is_complete", want.name_is_complete,
						res_ch.name_is_complete);
					check_field("record_done", want.record_done, res_ch.record_done);
					if (want.char_write)
						chars_written++;
				end
				results_checked++;
			end
			res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Watchdog: cycles with no item moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (rec_ch.valid && rec_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Register write over APB: setup cycle, then access cycle
	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({REG_NAME_CAPACITY, 2'b00});
		pwdata  <= ({$urandom()} & ~32'h7F) | 32'(cap);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cap_reg = cap;
		cap_writes++;
	endtask

	// Wait until every byte is in and every result is out, then let it settle
	task automatic wait_idle();
		do
			@(negedge clk);
		while (byte_backlog.size() != 0 || rec_ch.valid || name_expect.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [7:0] name_char();
		if ($urandom_range(99) < 70)
			return 8'($urandom_range(32, 126));
		return 8'($urandom_range(255));
	endfunction

	// Append one AD structure: length, type, payload
	task automatic add_structure(input int unsigned name_pct);
		int unsigned plen;
		logic [7:0]  kind;
		plen = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 12);
		if ($urandom_range(99) < name_pct)
			kind = $urandom_range(1) ? AD_COMPLETE_NAME : AD_SHORT_NAME;
		else
			kind = 8'($urandom_range(255));
		rec_buf.push_back(8'(plen + 1));
		rec_buf.push_back(kind);
		repeat (plen) rec_buf.push_back(name_char());
	endtask

	// Move the record into the backlog; remaining counts follow the claimed size
	// or, when scrambled, are random until the final byte
	task automatic emit_record(input int unsigned claimed, input bit scramble);
		adv_byte_t ab;
		int unsigned n;
		n = rec_buf.size();
		for (int unsigned i = 0; i < n; i++) begin
			ab.data_byte = rec_buf[i];
			if (i == n - 1)
				ab.bytes_remaining = 8'd0;
			else if (scramble)
				ab.bytes_remaining = 8'($urandom_range(1, 254));
			else
				ab.bytes_remaining = 8'(claimed - 1 - i);
			byte_backlog.push_back(ab);
		end
		rec_buf.delete();
	endtask

	// Main sequence
	initial begin
		int unsigned seg_count;
		int unsigned kind;
		int unsigned claimed;
		int unsigned l;
		int unsigned extra;
		logic [CAP_W-1:0] cap;

		arst_n                 = 1'b0;
		psel                   = 1'b0;
		penable                = 1'b0;
		pwrite                 = 1'b0;
		paddr                  = '0;
		pwdata                 = '0;
		rec_ch.valid           = 1'b0;
		rec_ch.data_byte       = '0;
		rec_ch.bytes_remaining = '0;
		res_ch.ready           = 1'b0;
		cap_reg                = CAPACITY_RESET;
		stall_cycles           = 0;
		bytes_accepted         = 0;
		results_checked        = 0;
		chars_written          = 0;
		cap_writes             = 0;
		mismatches             = 0;
		clear_scan();
		src_idle_pct  = 26;
		sink_idle_pct = 55;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, at the reset capacity.
		// Complete name with unprintable bytes, then bytes after the stop
		rec_buf = '{8'h04, AD_COMPLETE_NAME, 8'h41, 8'h1F, 8'hFF, 8'h02, AD_SHORT_NAME, 8'h42};
		emit_record(8, 1'b0);
		// Flags, shortened name at the printable edges, type-only name,
		// zero length, then an ignored byte
		rec_buf = '{8'h02, 8'h01, 8'h06, 8'h03, AD_SHORT_NAME, CHAR_LAST, CHAR_FIRST,
			8'h01, AD_SHORT_NAME, 8'h00, 8'h05};
		emit_record(11, 1'b0);
		// Record claims more bytes than it has and ends inside a name
		rec_buf = '{8'h06, AD_SHORT_NAME, 8'h61};
		emit_record(11, 1'b0);
		// Length overrunning the record
		rec_buf = '{8'h05, AD_SHORT_NAME, 8'h41};
		emit_record(3, 1'b0);
		rec_buf = '{8'hFF};
		emit_record(1, 1'b0);
		wait_idle();

		// Random records under a sequence of capacities and stall patterns
		for (int unsigned s = 1; s <= RAND_SEGMENTS; s++) begin
			if (s <= 2) begin
				src_idle_pct  = 26;
				sink_idle_pct = 55;
			end else if (s <= 5) begin
				src_idle_pct  = 55;
				sink_idle_pct = 26;
			end else begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			case (s)
				1:       cap = 7'd64;
				2:       cap = 7'd0;
				3:       cap = 7'($urandom_range(2, 63));
				4:       cap = 7'd1;
				5:       cap = 7'd127;
				6:       cap = 7'($urandom_range(2, 20));
				7:       cap = 7'd64;
				8:       cap = 7'd0;
				default: cap = 7'($urandom_range(0, 127));
			endcase
			write_capacity(cap);

			seg_count = 0;
			while (seg_count < SEG_ITEMS) begin
				kind = $urandom_range(99);
				if (kind < 85) begin
					repeat ($urandom_range(1, 4))
						if (rec_buf.size() < 80)
							add_structure(45);
					claimed = rec_buf.size();
					if (kind >= 65) begin
						case ($urandom_range(2))
							0: begin
								// zero length mid-record
								rec_buf.push_back(8'h00);
								add_structure(45);
							end
							1: begin
								// last structure overruns the record
								l = rec_buf.size();
								add_structure(45);
								rec_buf[l] = 8'($urandom_range(rec_buf.size() - l, 255));
							end
							default: begin
								// record ends inside the last structure
								l = rec_buf.size();
								add_structure(45);
								extra = $urandom_range(1, 15);
								rec_buf[l] = rec_buf[l] + 8'(extra);
								claimed = rec_buf.size() + extra;
							end
						endcase
						if (claimed < rec_buf.size())
							claimed = rec_buf.size();
					end
					seg_count += rec_buf.size();
					emit_record(claimed, 1'b0);
				end else begin
					// noise with random remaining counts
					repeat ($urandom_range(1, 8))
						rec_buf.push_back(8'($urandom_range(255)));
					seg_count += rec_buf.size();
					emit_record(0, 1'b1);
				end
			end
			wait_idle();
		end

		$display("Covered %0d record bytes, %0d results checked, %0d name characters,",
			bytes_accepted, results_checked, chars_written);
		$display("over %0d capacity settings with stalls on both channels; %0d mismatches.",
			cap_writes + 1, mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/adnp_pkg.sv
rtl/adnp_in_if.sv
rtl/adnp_out_if.sv
rtl/adnp_core.sv
rtl/adv_data_name_parser.sv
bench/tb_adv_data_name_parser.sv
